>>> rtl/core/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants of the serial file transfer receiver.
// ----------------------------------------------------------------------------
package sft_pkg;

    localparam int MAX_DIGITS = 30;
    localparam int SIZE_WIDTH = 24;
    localparam int SYNC_LEN   = 12;
    localparam int DIG_W      = $clog2(MAX_DIGITS);
    localparam int ACC_W      = (SIZE_WIDTH + 1 > 16) ? SIZE_WIDTH + 1 : 16;
    localparam int VAL_W      = 24;
    localparam int KIND_W     = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0] SYNC_PAT [SYNC_LEN] = '{
        8'h73, 8'h65, 8'h72, 8'h69, 8'h61, 8'h6c,
        8'h20, 8'h73, 8'h79, 8'h6e, 8'h63, 8'h0a
    };

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_LF   = 8'h0a;

    localparam logic [KIND_W-1:0] K_SYNC   = 3'd0;
    localparam logic [KIND_W-1:0] K_MODE   = 3'd1;
    localparam logic [KIND_W-1:0] K_HEADER = 3'd2;
    localparam logic [KIND_W-1:0] K_BYTE   = 3'd3;
    localparam logic [KIND_W-1:0] K_OK     = 3'd4;
    localparam logic [KIND_W-1:0] K_ERROR  = 3'd5;

    localparam logic [VAL_W-1:0] E_MODE   = 24'd1;
    localparam logic [VAL_W-1:0] E_DIGITS = 24'd2;
    localparam logic [VAL_W-1:0] E_SIZE   = 24'd3;
    localparam logic [VAL_W-1:0] E_HEX    = 24'd4;
    localparam logic [VAL_W-1:0] E_LF     = 24'd5;
    localparam logic [VAL_W-1:0] E_SUM    = 24'd6;

    // classified word passed from front to back
    typedef struct packed {
        logic [7:0] rx;
        logic       sync_hit;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] nibble;
    } t_item;

endpackage

>>> rtl/core/sft_front.sv
// ----------------------------------------------------------------------------
// sft_front
// Keeps the sync window and classifies each received word.
// ----------------------------------------------------------------------------
module sft_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_rx,
    output sft_pkg::t_item o_item
);

    logic [7:0] r_win [sft_pkg::SYNC_LEN];
    logic [7:0] w_next [sft_pkg::SYNC_LEN];
    logic       w_hit;
    logic       w_dig;
    logic       w_lc;
    logic       w_uc;

    always_comb begin
        for (int i = 0; i < sft_pkg::SYNC_LEN - 1; i++) begin
            w_next[i] = r_win[i+1];
        end
        w_next[sft_pkg::SYNC_LEN-1] = i_rx;
        w_hit = 1'b1;
        for (int i = 0; i < sft_pkg::SYNC_LEN; i++) begin
            if (w_next[i] != sft_pkg::SYNC_PAT[i]) begin
                w_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sft_pkg::SYNC_LEN; i++) begin
                r_win[i] <= 8'h00;
            end
        end else if (i_take) begin
            r_win <= w_next;
        end
    end

    assign w_dig = (i_rx >= 8'h30) && (i_rx <= 8'h39);
    assign w_lc  = (i_rx >= 8'h61) && (i_rx <= 8'h66);
    assign w_uc  = (i_rx >= 8'h41) && (i_rx <= 8'h46);

    assign o_item.rx       = i_rx;
    assign o_item.sync_hit = w_hit;
    assign o_item.is_digit = w_dig;
    assign o_item.is_hex   = w_dig || w_lc || w_uc;
    assign o_item.nibble   = w_dig ? i_rx[3:0] : (i_rx[3:0] + 4'd9);

endmodule

>>> rtl/core/sft_fifo.sv
// ----------------------------------------------------------------------------
// sft_fifo
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sft_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sft_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sft_pkg::t_item o_item
);

    localparam int PW = $clog2(sft_pkg::FIFO_DEPTH);

    sft_pkg::t_item r_mem [sft_pkg::FIFO_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;
    logic [PW:0]    n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(sft_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/sft_back.sv
// ----------------------------------------------------------------------------
// sft_back
// Protocol sequencer: sync hunt, header parsing, hex decoding, sum check, result register.
// ----------------------------------------------------------------------------
module sft_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_avail,
    input  sft_pkg::t_item               i_item,
    input  logic [sft_pkg::VAL_W-1:0]    i_limit,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sft_pkg::KIND_W-1:0]   o_kind,
    output logic [sft_pkg::VAL_W-1:0]    o_value,
    output logic                         o_file_index,
    output logic                         o_last
);

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_MODE  = 4'd1;
    localparam logic [3:0] PH_CSUM  = 4'd2;
    localparam logic [3:0] PH_SIZE  = 4'd3;
    localparam logic [3:0] PH_HEXHI = 4'd4;
    localparam logic [3:0] PH_HEXLO = 4'd5;
    localparam logic [3:0] PH_LF    = 4'd6;
    localparam logic [3:0] PH_DONE  = 4'd7;
    localparam logic [3:0] PH_ERROR = 4'd8;

    localparam int AW = sft_pkg::ACC_W;
    localparam int PW = sft_pkg::ACC_W + 4;
    localparam int SW = sft_pkg::SIZE_WIDTH;
    localparam logic [PW-1:0] CAP = PW'(1) << SW;

    logic [3:0]                      r_phase, n_phase;
    logic [sft_pkg::DIG_W-1:0]       r_dcnt, n_dcnt;
    logic [AW-1:0]                   r_acc, n_acc;
    logic [15:0]                     r_exp, n_exp;
    logic [15:0]                     r_sum, n_sum;
    logic [SW-1:0]                   r_left, n_left;
    logic [3:0]                      r_hi, n_hi;
    logic                            r_file, n_file;
    logic                            r_valid;
    logic [sft_pkg::KIND_W-1:0]      r_kind;
    logic [sft_pkg::VAL_W-1:0]       r_value;
    logic                            r_fidx;
    logic                            r_last;

    logic                            w_emit;
    logic [sft_pkg::KIND_W-1:0]      w_kind;
    logic [sft_pkg::VAL_W-1:0]       w_value;
    logic                            w_last;
    logic [PW-1:0]                   w_prod;
    logic [7:0]                      w_byte;
    logic [SW-1:0]                   w_left_dec;

    assign o_pop        = i_avail && (!r_valid || i_ready);
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_value      = r_value;
    assign o_file_index = r_fidx;
    assign o_last       = r_last;

    assign w_prod     = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(i_item.rx[3:0]);
    assign w_byte     = {r_hi, i_item.nibble};
    assign w_left_dec = r_left - 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_acc   = r_acc;
        n_exp   = r_exp;
        n_sum   = r_sum;
        n_left  = r_left;
        n_hi    = r_hi;
        n_file  = r_file;
        w_emit  = 1'b0;
        w_kind  = sft_pkg::K_SYNC;
        w_value = '0;
        w_last  = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_item.sync_hit) begin
                    w_emit  = 1'b1;
                    n_phase = PH_MODE;
                end
            end
            PH_MODE: begin
                w_emit = 1'b1;
                if (i_item.rx == sft_pkg::CH_ZERO || i_item.rx == sft_pkg::CH_ONE) begin
                    w_kind  = sft_pkg::K_MODE;
                    w_value = sft_pkg::VAL_W'(i_item.rx[0]);
                    n_phase = PH_CSUM;
                    n_dcnt  = '0;
                    n_acc   = '0;
                end else begin
                    w_kind  = sft_pkg::K_ERROR;
                    w_value = sft_pkg::E_MODE;
                    n_phase = PH_ERROR;
                end
            end
            PH_CSUM, PH_SIZE: begin
                if (i_item.is_digit) begin
                    if (r_dcnt >= sft_pkg::DIG_W'(sft_pkg::MAX_DIGITS - 1)) begin
                        w_emit  = 1'b1;
                        w_kind  = sft_pkg::K_ERROR;
                        w_value = sft_pkg::E_DIGITS;
                        n_phase = PH_ERROR;
                    end else begin
                        n_dcnt = r_dcnt + 1'b1;
                        if (r_phase == PH_CSUM) begin
                            n_acc = AW'(w_prod[15:0]);
                        end else if (w_prod > CAP) begin
                            n_acc = AW'(CAP);
                        end else begin
                            n_acc = AW'(w_prod);
                        end
                    end
                end else if (r_phase == PH_CSUM) begin
                    n_exp   = r_acc[15:0];
                    n_phase = PH_SIZE;
                    n_dcnt  = '0;
                    n_acc   = '0;
                end else if (r_acc > AW'(i_limit)) begin
                    w_emit  = 1'b1;
                    w_kind  = sft_pkg::K_ERROR;
                    w_value = sft_pkg::E_SIZE;
                    n_phase = PH_ERROR;
                end else begin
                    w_emit  = 1'b1;
                    w_kind  = sft_pkg::K_HEADER;
                    w_value = sft_pkg::VAL_W'(r_acc);
                    n_left  = SW'(r_acc);
                    n_sum   = '0;
                    if (r_acc == '0) begin
                        if (!r_file) begin
                            n_file  = 1'b1;
                            n_phase = PH_CSUM;
                            n_dcnt  = '0;
                            n_acc   = '0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_phase = PH_HEXHI;
                    end
                end
            end
            PH_HEXHI: begin
                if (i_item.is_hex) begin
                    n_hi    = i_item.nibble;
                    n_phase = PH_HEXLO;
                end else begin
                    w_emit  = 1'b1;
                    w_kind  = sft_pkg::K_ERROR;
                    w_value = sft_pkg::E_HEX;
                    n_phase = PH_ERROR;
                end
            end
            PH_HEXLO: begin
                w_emit = 1'b1;
                if (i_item.is_hex) begin
                    w_kind  = sft_pkg::K_BYTE;
                    w_value = sft_pkg::VAL_W'(w_byte);
                    w_last  = (w_left_dec == '0);
                    n_sum   = r_sum + 16'(w_byte);
                    n_left  = w_left_dec;
                    n_phase = PH_LF;
                end else begin
                    w_kind  = sft_pkg::K_ERROR;
                    w_value = sft_pkg::E_HEX;
                    n_phase = PH_ERROR;
                end
            end
            PH_LF: begin
                if (i_item.rx != sft_pkg::CH_LF) begin
                    w_emit  = 1'b1;
                    w_kind  = sft_pkg::K_ERROR;
                    w_value = sft_pkg::E_LF;
                    n_phase = PH_ERROR;
                end else if (r_left != '0) begin
                    n_phase = PH_HEXHI;
                end else if (r_sum != r_exp) begin
                    w_emit  = 1'b1;
                    w_kind  = sft_pkg::K_ERROR;
                    w_value = sft_pkg::E_SUM;
                    n_phase = PH_ERROR;
                end else begin
                    w_emit  = 1'b1;
                    w_kind  = sft_pkg::K_OK;
                    w_value = sft_pkg::VAL_W'(r_sum);
                    if (!r_file) begin
                        n_file  = 1'b1;
                        n_phase = PH_CSUM;
                        n_dcnt  = '0;
                        n_acc   = '0;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_dcnt  <= '0;
            r_acc   <= '0;
            r_exp   <= '0;
            r_sum   <= '0;
            r_left  <= '0;
            r_hi    <= '0;
            r_file  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_dcnt  <= n_dcnt;
                r_acc   <= n_acc;
                r_exp   <= n_exp;
                r_sum   <= n_sum;
                r_left  <= n_left;
                r_hi    <= n_hi;
                r_file  <= n_file;
                r_valid <= w_emit;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_kind  <= w_kind;
            r_value <= w_value;
            r_fidx  <= r_file;
            r_last  <= w_last;
        end
    end

endmodule

>>> rtl/core/serial_file_transfer_receiver.sv
// ----------------------------------------------------------------------------
// serial_file_transfer_receiver
// A word's result passes through the queue and the result register before reaching the outputs.
// Throughput: the sequencer retires one queued word per cycle while no result waits on i_ready.
// Input side stalls only when the two-entry queue is full.
// Reset (synchronous, active low) clears window, sequencer, queue and sets size_limit to all ones.
// ----------------------------------------------------------------------------
module serial_file_transfer_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [23:0] o_value,
    output logic        o_file_index,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [sft_pkg::VAL_W-1:0] r_limit;
    logic                      w_take;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_pop;
    sft_pkg::t_item            w_fitem;
    sft_pkg::t_item            w_bitem;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? 32'(r_limit) : 32'h0;
    assign o_ready = !w_full;
    assign w_take  = i_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_limit <= pwdata[sft_pkg::VAL_W-1:0];
        end
    end

    sft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_rx    (i_rx_byte),
        .o_item  (w_fitem)
    );

    sft_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_bitem)
    );

    sft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (!w_empty),
        .i_item       (w_bitem),
        .i_limit      (r_limit),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_file_index (o_file_index),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_kind == sft_pkg::K_ERROR) |=> !o_valid)
        else $error("result after error");
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind == sft_pkg::K_BYTE))
        else $error("last flag on non-byte result");
    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == sft_pkg::K_BYTE) |-> (o_value[23:8] == 16'h0))
        else $error("payload byte out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue read while empty");
`endif

endmodule
